### rtl/lcit_pkg.sv
// Shared constants, payload types and register codes for the load cell intake tracker.
package lcit_pkg;

   localparam int unsigned SAMPLES     = 50;
   localparam int unsigned COUNT_W     = $clog2(SAMPLES + 1);
   localparam int unsigned SUM_W       = 31;
   localparam int unsigned RECIP_SHIFT = 31;
   localparam logic [31:0] RECIP       = 32'((64'd1 << RECIP_SHIFT) / SAMPLES);

   localparam logic [23:0] SIGN_FLIP  = 24'h800000;
   localparam logic [23:0] TARE_RESET = 24'd7831281;
   localparam logic [23:0] GAIN_RESET = 24'd170079;
   localparam logic [39:0] TOTAL_MAX  = 40'hFF_FFFF_FFFF;

   localparam int unsigned DIV_W     = 40;
   localparam int unsigned DIV_SPLIT = 20;
   localparam int unsigned HI_W      = DIV_W - DIV_SPLIT;
   localparam int unsigned HI_Q_W    = 11;
   localparam int unsigned REM_W     = 10;
   localparam int unsigned LO_N_W    = REM_W + DIV_SPLIT;
   localparam int unsigned LO_Q_W    = DIV_SPLIT;
   localparam int unsigned QUOT_W    = HI_Q_W + LO_Q_W;
   localparam logic [10:0] MG_PER_ML = 11'd1000;
   localparam logic [10:0] RECIP_HI  = 11'((64'd1 << HI_W) / 64'(MG_PER_ML));
   localparam logic [20:0] RECIP_LO  = 21'((64'd1 << LO_N_W) / 64'(MG_PER_ML));

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      REG_TARE = 1'b0,
      REG_GAIN = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [23:0] raw_word;
      logic        timed_out;
      logic [4:0]  day_of_month;
   } req_type;

   typedef struct packed {
      logic signed [32:0] weight_mg;
      logic signed [23:0] volume_ml;
      logic [30:0]        intake_ml;
      logic               is_baseline;
      logic               day_rolled;
   } rsp_type;

   typedef struct packed {
      logic [SUM_W-1:0] sample_sum;
      logic [4:0]       day_of_month;
   } batch_type;

endpackage

### rtl/load_cell_intake_tracker_unit.sv
// Top level of the load cell intake tracker with its register port and batch queue.
//
// The block takes one conversion word per clock while the queue is not full and gives one
// result word per batch of SAMPLES words. The front end sums words at full rate unless the
// queue is full; each finished batch waits in a two-entry queue for the back end, which
// takes the batch from the queue, averages, tares, scales and totals it, divides by one
// thousand for the volume and the daily total, then loads the result register once that
// register is free. Input is taken every clock as long as results are popped; full goes
// high only while both queue entries are occupied, which happens when result words are
// left waiting.
// Registers should be written only while the block is idle.
module load_cell_intake_tracker_unit
   import lcit_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  req_type     req_data,
   output logic        req_full,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [23:0]   tare_ff, tare_in;
   logic [23:0]   gain_ff, gain_in;
   logic          csr_write;
   csr_index_type csr_index;
   logic          q_push;
   logic          q_full;
   logic          q_pop;
   logic          q_empty;
   batch_type     q_wr_data;
   batch_type     q_rd_data;

   lcit_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_wr_data)
   );

   lcit_batch_q u_batch_q (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rd_data),
      .empty     (q_empty)
   );

   lcit_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_data      (q_rd_data),
      .q_pop       (q_pop),
      .tare_offset (tare_ff),
      .gain_q16    (gain_ff),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data)
   );

   always_comb begin
      csr_pready = 1'b1;
      csr_index  = csr_index_type'(csr_paddr[2]);
      csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
      tare_in    = tare_ff;
      gain_in    = gain_ff;
      unique case (csr_index)
         REG_TARE: csr_prdata = {8'd0, tare_ff};
         REG_GAIN: csr_prdata = {8'd0, gain_ff};
         default:  csr_prdata = 32'd0;
      endcase
      if (csr_write) begin
         unique case (csr_index)
            REG_TARE: tare_in = csr_pwdata[23:0];
            REG_GAIN: gain_in = csr_pwdata[23:0];
            default:  tare_in = tare_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tare_ff <= TARE_RESET;
         gain_ff <= GAIN_RESET;
      end else begin
         tare_ff <= tare_in;
         gain_ff <= gain_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("batch queue written while full");

   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("batch queue read while empty");

   assert property (@(posedge clock) disable iff (reset)
      (q_push && !q_pop) |=> !q_empty)
      else $error("batch queue lost a pushed word");

endmodule

### rtl/lcit_front.sv
// Front end: converts conversion words to samples and sums them into batches.
module lcit_front
   import lcit_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_push,
   input  req_type   req_data,
   output logic      req_full,
   input  logic      q_full,
   output logic      q_push,
   output batch_type q_data
);

   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [23:0]        sample;
   logic [SUM_W-1:0]   batch_sum;
   logic               accept;
   logic               last;

   always_comb begin
      sample    = req_data.timed_out ? 24'd0 : (req_data.raw_word ^ SIGN_FLIP);
      accept    = req_push && !q_full;
      last      = (count_ff == COUNT_W'(SAMPLES - 1));
      batch_sum = sum_ff + SUM_W'(sample);
      req_full  = q_full;
      q_push    = accept && last;
      q_data.sample_sum   = batch_sum;
      q_data.day_of_month = req_data.day_of_month;
      sum_in   = sum_ff;
      count_in = count_ff;
      if (accept) begin
         if (last) begin
            sum_in   = '0;
            count_in = '0;
         end else begin
            sum_in   = batch_sum;
            count_in = count_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

endmodule

### rtl/lcit_batch_q.sv
// Two-entry queue of finished batch sums between the front and back ends.
module lcit_batch_q
   import lcit_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  batch_type push_data,
   output logic      full,
   input  logic      pop,
   output batch_type pop_data,
   output logic      empty
);

   batch_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   always_comb begin
      full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
      empty     = (count_ff == '0);
      do_push   = push && !full;
      do_pop    = pop && !empty;
      pop_data  = mem_ff[rd_ptr_ff];
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/lcit_div1000.sv
// Divider by one thousand built from reciprocal multiplications on the upper and lower halves.
module lcit_div1000
   import lcit_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  dividend,
   output logic              busy,
   output logic [QUOT_W-1:0] quotient
);

   typedef enum logic [1:0] {
      ST_HI_MUL,
      ST_HI_FIX,
      ST_LO_MUL,
      ST_LO_FIX
   } state_type;

   state_type           state_ff, state_in;
   logic [DIV_W-1:0]    num_ff, num_in;
   logic                busy_ff, busy_in;
   logic [HI_Q_W-1:0]   hi_q_ff, hi_q_in;
   logic [LO_N_W-1:0]   lo_num_ff, lo_num_in;
   logic [LO_Q_W-1:0]   lo_q_ff, lo_q_in;
   logic [QUOT_W-1:0]   quot_ff, quot_in;
   logic [HI_W+10:0]    hi_prod;
   logic [LO_N_W+20:0]  lo_prod;
   logic [HI_W-1:0]     hi_num;
   logic [HI_W-1:0]     hi_rem;
   logic [LO_N_W-1:0]   lo_rem;
   logic [REM_W-1:0]    hi_rem_fixed;
   logic                hi_fits;
   logic                lo_fits;

   always_comb begin
      hi_num       = num_ff[DIV_W-1 -: HI_W];
      hi_prod      = hi_num * RECIP_HI;
      hi_rem       = hi_num - HI_W'(hi_q_ff) * HI_W'(MG_PER_ML);
      hi_fits      = (hi_rem >= HI_W'(MG_PER_ML));
      hi_rem_fixed = hi_fits ? REM_W'(hi_rem - HI_W'(MG_PER_ML)) : hi_rem[REM_W-1:0];
      lo_prod      = lo_num_ff * RECIP_LO;
      lo_rem       = lo_num_ff - LO_N_W'(lo_q_ff) * LO_N_W'(MG_PER_ML);
      lo_fits      = (lo_rem >= LO_N_W'(MG_PER_ML));
      busy         = busy_ff;
      quotient     = quot_ff;
      state_in     = state_ff;
      num_in       = num_ff;
      busy_in      = busy_ff;
      hi_q_in      = hi_q_ff;
      lo_num_in    = lo_num_ff;
      lo_q_in      = lo_q_ff;
      quot_in      = quot_ff;
      if (start) begin
         num_in   = dividend;
         state_in = ST_HI_MUL;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         unique case (state_ff)
            ST_HI_MUL: begin
               hi_q_in  = hi_prod[HI_W +: HI_Q_W];
               state_in = ST_HI_FIX;
            end
            ST_HI_FIX: begin
               hi_q_in   = hi_q_ff + HI_Q_W'(hi_fits);
               lo_num_in = {hi_rem_fixed, num_ff[DIV_SPLIT-1:0]};
               state_in  = ST_LO_MUL;
            end
            ST_LO_MUL: begin
               lo_q_in  = lo_prod[LO_N_W +: LO_Q_W];
               state_in = ST_LO_FIX;
            end
            ST_LO_FIX: begin
               quot_in  = {hi_q_ff, lo_q_ff + LO_Q_W'(lo_fits)};
               busy_in  = 1'b0;
               state_in = ST_HI_MUL;
            end
            default: begin
               state_in = ST_HI_MUL;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      num_ff    <= num_in;
      hi_q_ff   <= hi_q_in;
      lo_num_ff <= lo_num_in;
      lo_q_ff   <= lo_q_in;
      quot_ff   <= quot_in;
      if (reset) begin
         state_ff <= ST_HI_MUL;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

endmodule

### rtl/lcit_back.sv
// Back end: averages, tares and scales each batch and keeps the daily intake total.
module lcit_back
   import lcit_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  batch_type   q_data,
   output logic        q_pop,
   input  logic [23:0] tare_offset,
   input  logic [23:0] gain_q16,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RECIP,
      ST_FIX,
      ST_SCALE,
      ST_WEIGHT,
      ST_TOTAL,
      ST_DIV
   } state_type;

   state_type          state_ff, state_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [4:0]         day_ff, day_in;
   logic [23:0]        q0_ff, q0_in;
   logic signed [24:0] delta_ff, delta_in;
   logic signed [48:0] prod_ff, prod_in;
   logic signed [32:0] weight_ff, weight_in;
   logic signed [32:0] last_ff, last_in;
   logic [4:0]         prev_day_ff, prev_day_in;
   logic [39:0]        total_ff, total_in;
   logic               base_done_ff, base_done_in;
   logic               base_ff, base_in;
   logic               rolled_ff, rolled_in;
   logic               neg_ff, neg_in;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_ff, out_in;

   logic [62:0]        recip_prod;
   logic [SUM_W-1:0]   q0_times;
   logic [SUM_W-1:0]   rem;
   logic [23:0]        avg;
   logic signed [24:0] delta_calc;
   logic signed [48:0] scale_prod;
   logic signed [32:0] weight_calc;
   logic               round_up;
   logic [33:0]        drop;
   logic               drop_pos;
   logic [39:0]        base_total;
   logic [40:0]        total_sum;
   logic [39:0]        total_sat;
   logic [32:0]        mag;
   logic               div_start;
   logic [QUOT_W-1:0]  vol_q, daily_q;
   logic               vol_busy, daily_busy;
   logic [23:0]        vol_lo;

   lcit_div1000 u_vol_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (DIV_W'(mag)),
      .busy     (vol_busy),
      .quotient (vol_q)
   );

   lcit_div1000 u_daily_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (total_in),
      .busy     (daily_busy),
      .quotient (daily_q)
   );

   always_comb begin
      recip_prod  = sum_ff * RECIP;
      q0_times    = SUM_W'(q0_ff) * SUM_W'(SAMPLES);
      rem         = sum_ff - q0_times;
      avg         = q0_ff + 24'(rem >= SUM_W'(SAMPLES));
      delta_calc  = $signed({1'b0, avg}) - $signed({1'b0, tare_offset});
      scale_prod  = delta_ff * $signed({1'b0, gain_q16});
      round_up    = prod_ff[48] && (prod_ff[15:0] != 16'd0);
      weight_calc = $signed(prod_ff[48:16]) + $signed({32'd0, round_up});
      drop        = {last_ff[32], last_ff} - {weight_ff[32], weight_ff};
      drop_pos    = !drop[33] && (drop != 34'd0);
      base_total  = (day_ff != prev_day_ff) ? 40'd0 : total_ff;
      total_sum   = {1'b0, base_total} + (drop_pos ? 41'(drop[32:0]) : 41'd0);
      total_sat   = (total_sum >= {1'b0, TOTAL_MAX}) ? TOTAL_MAX : total_sum[39:0];
      mag         = weight_ff[32] ? (~weight_ff + 33'd1) : weight_ff;
      vol_lo      = vol_q[23:0];

      q_pop        = 1'b0;
      div_start    = 1'b0;
      state_in     = state_ff;
      sum_in       = sum_ff;
      day_in       = day_ff;
      q0_in        = q0_ff;
      delta_in     = delta_ff;
      prod_in      = prod_ff;
      weight_in    = weight_ff;
      last_in      = last_ff;
      prev_day_in  = prev_day_ff;
      total_in     = total_ff;
      base_done_in = base_done_ff;
      base_in      = base_ff;
      rolled_in    = rolled_ff;
      neg_in       = neg_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_in       = out_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               sum_in   = q_data.sample_sum;
               day_in   = q_data.day_of_month;
               state_in = ST_RECIP;
            end
         end
         ST_RECIP: begin
            q0_in    = recip_prod[RECIP_SHIFT +: 24];
            state_in = ST_FIX;
         end
         ST_FIX: begin
            delta_in = delta_calc;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            prod_in  = scale_prod;
            state_in = ST_WEIGHT;
         end
         ST_WEIGHT: begin
            weight_in = weight_calc;
            state_in  = ST_TOTAL;
         end
         ST_TOTAL: begin
            div_start   = 1'b1;
            prev_day_in = day_ff;
            last_in     = weight_ff;
            neg_in      = weight_ff[32];
            if (!base_done_ff) begin
               base_done_in = 1'b1;
               base_in      = 1'b1;
               rolled_in    = 1'b0;
            end else begin
               base_in   = 1'b0;
               rolled_in = (day_ff != prev_day_ff);
               total_in  = total_sat;
            end
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!vol_busy && !daily_busy && (!out_valid_ff || rsp_pop)) begin
               out_valid_in       = 1'b1;
               out_in.weight_mg   = weight_ff;
               out_in.volume_ml   = neg_ff ? (~vol_lo + 24'd1) : vol_lo;
               out_in.intake_ml   = daily_q[30:0];
               out_in.is_baseline = base_ff;
               out_in.day_rolled  = rolled_ff;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_empty = !out_valid_ff;
      rsp_data  = out_ff;
   end

   always_ff @(posedge clock) begin
      sum_ff    <= sum_in;
      day_ff    <= day_in;
      q0_ff     <= q0_in;
      delta_ff  <= delta_in;
      prod_ff   <= prod_in;
      weight_ff <= weight_in;
      base_ff   <= base_in;
      rolled_ff <= rolled_in;
      neg_ff    <= neg_in;
      out_ff    <= out_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_ff      <= '0;
         prev_day_ff  <= '0;
         total_ff     <= '0;
         base_done_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         prev_day_ff  <= prev_day_in;
         total_ff     <= total_in;
         base_done_ff <= base_done_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule
